/* hw/rtl/disk_transfer_bounds_check_macros.svh */
// Assertion macros shared by the transfer bounds check RTL
`ifndef DISK_TRANSFER_BOUNDS_CHECK_MACROS_SVH
`define DISK_TRANSFER_BOUNDS_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DTBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DTBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dtbc_pkg.sv */
// Shared widths, codes and types of the transfer bounds check
`default_nettype none

package dtbc_pkg;

    // Field widths
    localparam int BLK_W     = 32;
    localparam int CNT_W     = 24;
    localparam int SCL_W     = 7;
    localparam int SPC_W     = 24;
    localparam int OFF_W     = 32;
    localparam int CYL_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Scaled partition size/offset, and absolute block (sum of two)
    localparam int SIZE_W = BLK_W + SCL_W;
    localparam int ABS_W  = SIZE_W + 1;

    // Block size exponent default and label location within raw partition
    localparam int BLOCK_SHIFT_DEF = 9;
    localparam int LABEL_SECTOR    = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_OFF = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EOF     = 2'd1,
        ST_INVALID = 2'd2,
        ST_LABEL   = 2'd3
    } t_status;

    // Result fields that ride along the divider chain
    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   cnt_out;
        logic [CNT_W-1:0]   resid;
    } t_meta;

    // Configuration registers
    typedef struct packed {
        logic [SPC_W-1:0]   spc;
        logic [SCL_W-1:0]   scale;
        logic [OFF_W-1:0]   raw_off;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/dtbc_front.sv */
// Front end: scaling, partition bounds, truncation and label protection
`default_nettype none
`include "disk_transfer_bounds_check_macros.svh"

module dtbc_front #(
    parameter int BLOCK_SHIFT = dtbc_pkg::BLOCK_SHIFT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire dtbc_pkg::t_cfg                i_cfg,
    input  wire logic [dtbc_pkg::BLK_W-1:0]    i_block_number,
    input  wire logic [dtbc_pkg::CNT_W-1:0]    i_byte_count,
    input  wire logic                          i_is_read,
    input  wire logic                          i_label_writable,
    input  wire logic [dtbc_pkg::BLK_W-1:0]    i_partition_size,
    input  wire logic [dtbc_pkg::OFF_W-1:0]    i_partition_offset,
    output logic                               o_vld,
    output dtbc_pkg::t_meta                    o_meta,
    output logic [dtbc_pkg::ABS_W-1:0]         o_dividend,
    output logic [dtbc_pkg::SPC_W-1:0]         o_divisor
);

    localparam int SIZE_W = dtbc_pkg::SIZE_W;
    localparam int ABS_W  = dtbc_pkg::ABS_W;
    localparam int CNT_W  = dtbc_pkg::CNT_W;
    localparam int BLK_W  = dtbc_pkg::BLK_W;
    // Length in blocks, rounded up
    localparam int SZ_W   = CNT_W - BLOCK_SHIFT + 1;

    // Label block, follows the configuration registers
    logic [ABS_W-1:0]   r_label;

    always_ff @(posedge i_clk) begin
        r_label <= ABS_W'(i_cfg.raw_off) * ABS_W'(i_cfg.scale)
                   + ABS_W'(dtbc_pkg::LABEL_SECTOR);
    end

    // ---------------- stage 1: request capture ----------------
    logic                  r_s1_vld;
    logic [BLK_W-1:0]      r_s1_blk;
    logic [CNT_W-1:0]      r_s1_cnt;
    logic                  r_s1_rd;
    logic                  r_s1_wlab;
    logic [BLK_W-1:0]      r_s1_psize;
    logic [BLK_W-1:0]      r_s1_poff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_s1_blk   <= i_block_number;
            r_s1_cnt   <= i_byte_count;
            r_s1_rd    <= i_is_read;
            r_s1_wlab  <= i_label_writable;
            r_s1_psize <= i_partition_size;
            r_s1_poff  <= i_partition_offset;
        end
    end

    // Scale to 512-byte blocks; byte count to whole blocks
    logic [SIZE_W-1:0]  n_s2_psize;
    logic [SIZE_W-1:0]  n_s2_poff;
    logic [SZ_W-1:0]    n_s2_sz;

    assign n_s2_psize = SIZE_W'(r_s1_psize) * SIZE_W'(i_cfg.scale);
    assign n_s2_poff  = SIZE_W'(r_s1_poff) * SIZE_W'(i_cfg.scale);
    assign n_s2_sz    = SZ_W'(r_s1_cnt >> BLOCK_SHIFT)
                        + SZ_W'(|r_s1_cnt[BLOCK_SHIFT-1:0]);

    // ---------------- stage 2: partition bounds ----------------
    logic                  r_s2_vld;
    logic [BLK_W-1:0]      r_s2_blk;
    logic [CNT_W-1:0]      r_s2_cnt;
    logic                  r_s2_rd;
    logic                  r_s2_wlab;
    logic [SIZE_W-1:0]     r_s2_psize;
    logic [SIZE_W-1:0]     r_s2_poff;
    logic [SZ_W-1:0]       r_s2_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_blk   <= r_s1_blk;
        r_s2_cnt   <= r_s1_cnt;
        r_s2_rd    <= r_s1_rd;
        r_s2_wlab  <= r_s1_wlab;
        r_s2_psize <= n_s2_psize;
        r_s2_poff  <= n_s2_poff;
        r_s2_sz    <= n_s2_sz;
    end

    logic [SIZE_W-1:0]      w_blk_ext;
    logic [SIZE_W-1:0]      w_end;
    logic [SIZE_W-1:0]      w_room;
    logic                   w_over;
    dtbc_pkg::t_status      n_s3_status;
    logic [SZ_W-1:0]        n_s3_sz;
    logic [CNT_W-1:0]       n_s3_cnt_out;
    logic [ABS_W-1:0]       n_s3_abs;

    assign w_blk_ext = SIZE_W'(r_s2_blk);
    assign w_end     = w_blk_ext + SIZE_W'(r_s2_sz);
    assign w_room    = r_s2_psize - w_blk_ext;
    assign w_over    = w_end > r_s2_psize;
    assign n_s3_abs  = ABS_W'(r_s2_blk) + ABS_W'(r_s2_poff);

    // Zero geometry, end of partition, past the end, or truncation
    always_comb begin
        n_s3_status  = dtbc_pkg::ST_OK;
        n_s3_sz      = r_s2_sz;
        n_s3_cnt_out = r_s2_cnt;
        priority if (i_cfg.spc == '0) begin
            n_s3_status = dtbc_pkg::ST_INVALID;
        end else if (w_over) begin
            priority if (w_blk_ext == r_s2_psize) begin
                n_s3_status = dtbc_pkg::ST_EOF;
            end else if (w_blk_ext > r_s2_psize) begin
                n_s3_status = dtbc_pkg::ST_INVALID;
            end else begin
                // room left is below the requested length here
                n_s3_sz      = SZ_W'(w_room);
                n_s3_cnt_out = CNT_W'(w_room << BLOCK_SHIFT);
            end
        end else begin
            // fits inside the partition: defaults stand
        end
    end

    // ---------------- stage 3: label protection ----------------
    logic                  r_s3_vld;
    dtbc_pkg::t_status     r_s3_status;
    logic [CNT_W-1:0]      r_s3_cnt;
    logic [CNT_W-1:0]      r_s3_cnt_out;
    logic [SZ_W-1:0]       r_s3_sz;
    logic [ABS_W-1:0]      r_s3_abs;
    logic                  r_s3_rd;
    logic                  r_s3_wlab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_status  <= n_s3_status;
        r_s3_cnt     <= r_s2_cnt;
        r_s3_cnt_out <= n_s3_cnt_out;
        r_s3_sz      <= n_s3_sz;
        r_s3_abs     <= n_s3_abs;
        r_s3_rd      <= r_s2_rd;
        r_s3_wlab    <= r_s2_wlab;
    end

    logic               w_lbl_lo;
    logic               w_lbl_hi;
    dtbc_pkg::t_meta    n_s4_meta;

    assign w_lbl_lo = r_s3_abs <= r_label;
    assign w_lbl_hi = (dtbc_pkg::LABEL_SECTOR == 0)
                      || ((ABS_W+1)'(r_s3_abs) + (ABS_W+1)'(r_s3_sz) > (ABS_W+1)'(r_label));

    // Refuse an unprivileged write over the label; residual on any refusal
    always_comb begin
        n_s4_meta.status  = r_s3_status;
        n_s4_meta.cnt_out = r_s3_cnt_out;
        if (r_s3_status == dtbc_pkg::ST_OK && w_lbl_lo && w_lbl_hi
            && !r_s3_rd && !r_s3_wlab) begin
            n_s4_meta.status = dtbc_pkg::ST_LABEL;
        end
        n_s4_meta.resid = (n_s4_meta.status != dtbc_pkg::ST_OK) ? r_s3_cnt : '0;
    end

    // ---------------- stage 4: hand-off to divider chain ----------------
    logic                           r_s4_vld;
    dtbc_pkg::t_meta                r_s4_meta;
    logic [ABS_W-1:0]               r_s4_abs;
    logic [dtbc_pkg::SPC_W-1:0]     r_s4_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_meta <= n_s4_meta;
        r_s4_abs  <= r_s3_abs;
        r_s4_div  <= i_cfg.spc;
    end

    assign o_vld      = r_s4_vld;
    assign o_meta     = r_s4_meta;
    assign o_dividend = r_s4_abs;
    assign o_divisor  = r_s4_div;

    // Checks
    `DTBC_ASSERT_IMP(a_trunc_le_req, i_clk, i_rst_n, r_s3_vld, r_s3_cnt_out <= r_s3_cnt,
        "truncated length exceeds request")
    `DTBC_ASSERT_NXT(a_zero_geom_invalid, i_clk, i_rst_n, r_s2_vld && i_cfg.spc == '0,
        r_s3_status == dtbc_pkg::ST_INVALID, "zero geometry not flagged invalid")

endmodule

`default_nettype wire

/* hw/rtl/dtbc_div_cell.sv */
// One restoring-division cell: resolves one cylinder quotient bit per beat
`default_nettype none
`include "disk_transfer_bounds_check_macros.svh"

module dtbc_div_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire dtbc_pkg::t_meta               i_meta,
    input  wire logic [dtbc_pkg::SPC_W-1:0]    i_rem,
    input  wire logic [dtbc_pkg::ABS_W-1:0]    i_work,
    input  wire logic [dtbc_pkg::SPC_W-1:0]    i_divisor,
    output logic                               o_vld,
    output dtbc_pkg::t_meta                    o_meta,
    output logic [dtbc_pkg::SPC_W-1:0]         o_rem,
    output logic [dtbc_pkg::ABS_W-1:0]         o_work,
    output logic [dtbc_pkg::SPC_W-1:0]         o_divisor
);

    localparam int SPC_W = dtbc_pkg::SPC_W;
    localparam int ABS_W = dtbc_pkg::ABS_W;

    // Shift next dividend bit into remainder, subtract if it fits
    logic [SPC_W:0]     w_trial;
    logic [SPC_W:0]     w_diff;
    logic               w_ge;
    logic [SPC_W-1:0]   n_rem;
    logic [ABS_W-1:0]   n_work;

    assign w_trial = {i_rem, i_work[ABS_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign n_rem   = w_ge ? w_diff[SPC_W-1:0] : w_trial[SPC_W-1:0];
    // dividend shifts out the top, quotient bits fill in from the bottom
    assign n_work  = {i_work[ABS_W-2:0], w_ge};

    logic               r_vld;
    dtbc_pkg::t_meta    r_meta;
    logic [SPC_W-1:0]   r_rem;
    logic [ABS_W-1:0]   r_work;
    logic [SPC_W-1:0]   r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= i_meta;
        r_rem  <= n_rem;
        r_work <= n_work;
        r_div  <= i_divisor;
    end

    assign o_vld     = r_vld;
    assign o_meta    = r_meta;
    assign o_rem     = r_rem;
    assign o_work    = r_work;
    assign o_divisor = r_div;

    // Checks
    `DTBC_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_vld && r_div != '0, r_rem < r_div, "partial remainder not below divisor")

endmodule

`default_nettype wire

/* hw/rtl/disk_transfer_bounds_check.sv */
// Top level of the disk transfer bounds check
//
//  channel   direction  handshake            beat contents
//  request   in         start & !busy        block number, byte count, direction,
//                                            label permission, partition size/offset
//  config    in         i_cfg_we             register index and write data
//  result    out        o_strobe (1 cycle)   status, byte count, residual, cylinder
//
// One request is taken every cycle; busy stays low.
// The result is registered through four front stages for scaling, bounds and label checks,
// then one cell per quotient bit of the 40-bit cylinder division, then the output register.
// Synchronous active-low reset clears the valid chain and the configuration
// (sectors per cylinder 0, scale 1, raw offset 0). The result has no stall.
`default_nettype none
`include "disk_transfer_bounds_check_macros.svh"

module disk_transfer_bounds_check #(
    parameter int BLOCK_SHIFT = dtbc_pkg::BLOCK_SHIFT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [dtbc_pkg::BLK_W-1:0]        i_block_number,
    input  wire logic [dtbc_pkg::CNT_W-1:0]        i_byte_count,
    input  wire logic                              i_is_read,
    input  wire logic                              i_label_writable,
    input  wire logic [dtbc_pkg::BLK_W-1:0]        i_partition_size,
    input  wire logic [dtbc_pkg::OFF_W-1:0]        i_partition_offset,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [dtbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dtbc_pkg::CFG_W-1:0]        i_cfg_wdata,
    // result
    output logic                                   o_strobe,
    output logic [1:0]                             o_status,
    output logic [dtbc_pkg::CNT_W-1:0]             o_byte_count_out,
    output logic [dtbc_pkg::CNT_W-1:0]             o_residual_count,
    output logic [dtbc_pkg::CYL_W-1:0]             o_cylinder
);

    localparam int ABS_W = dtbc_pkg::ABS_W;
    localparam int SPC_W = dtbc_pkg::SPC_W;
    localparam int CYL_W = dtbc_pkg::CYL_W;
    localparam int LAT   = ABS_W + 5;

    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // Configuration registers
    dtbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spc     <= '0;
            r_cfg.scale   <= dtbc_pkg::SCL_W'(1);
            r_cfg.raw_off <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtbc_pkg::CFG_SPC:     r_cfg.spc     <= i_cfg_wdata[SPC_W-1:0];
                dtbc_pkg::CFG_SCALE:   r_cfg.scale   <= i_cfg_wdata[dtbc_pkg::SCL_W-1:0];
                dtbc_pkg::CFG_RAW_OFF: r_cfg.raw_off <= i_cfg_wdata[dtbc_pkg::OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Division chain links; link 0 is fed by the front end
    logic               c_vld  [ABS_W+1];
    dtbc_pkg::t_meta    c_meta [ABS_W+1];
    logic [SPC_W-1:0]   c_rem  [ABS_W+1];
    logic [ABS_W-1:0]   c_work [ABS_W+1];
    logic [SPC_W-1:0]   c_div  [ABS_W+1];

    dtbc_front #(
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vld              (w_accept),
        .i_cfg              (r_cfg),
        .i_block_number     (i_block_number),
        .i_byte_count       (i_byte_count),
        .i_is_read          (i_is_read),
        .i_label_writable   (i_label_writable),
        .i_partition_size   (i_partition_size),
        .i_partition_offset (i_partition_offset),
        .o_vld              (c_vld[0]),
        .o_meta             (c_meta[0]),
        .o_dividend         (c_work[0]),
        .o_divisor          (c_div[0])
    );

    assign c_rem[0] = '0;

    for (genvar g = 0; g < ABS_W; g++) begin : g_cell
        dtbc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (c_vld[g]),
            .i_meta    (c_meta[g]),
            .i_rem     (c_rem[g]),
            .i_work    (c_work[g]),
            .i_divisor (c_div[g]),
            .o_vld     (c_vld[g+1]),
            .o_meta    (c_meta[g+1]),
            .o_rem     (c_rem[g+1]),
            .o_work    (c_work[g+1]),
            .o_divisor (c_div[g+1])
        );
    end

    // Saturate the quotient to 32 bits; no cylinder on a refused request
    logic [ABS_W-1:0]   w_quot;
    logic [CYL_W-1:0]   n_cyl;

    assign w_quot = c_work[ABS_W];

    always_comb begin
        priority if (c_meta[ABS_W].status != dtbc_pkg::ST_OK) begin
            n_cyl = '0;
        end else if (|w_quot[ABS_W-1:CYL_W]) begin
            n_cyl = '1;
        end else begin
            n_cyl = w_quot[CYL_W-1:0];
        end
    end

    // Output register
    logic                           r_strobe;
    dtbc_pkg::t_meta                r_meta;
    logic [CYL_W-1:0]               r_cyl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= c_vld[ABS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= c_meta[ABS_W];
        r_cyl  <= n_cyl;
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_meta.status;
    assign o_byte_count_out = r_meta.cnt_out;
    assign o_residual_count = r_meta.resid;
    assign o_cylinder       = r_cyl;

    // Checks
    `DTBC_ASSERT_IMP(a_strobe_latency, i_clk, i_rst_n, o_strobe, $past(w_accept, LAT),
        "result without matching request")
    `DTBC_ASSERT_IMP(a_refused_whole, i_clk, i_rst_n,
        o_strobe && (o_status == dtbc_pkg::ST_EOF || o_status == dtbc_pkg::ST_INVALID),
        o_residual_count == o_byte_count_out, "refused request not returned whole")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench of the disk transfer bounds check: directed table, then random requests
`timescale 1ns / 1ps

module testbench;

    localparam int BLK_W        = dtbc_pkg::BLK_W;
    localparam int CNT_W        = dtbc_pkg::CNT_W;
    localparam int OFF_W        = dtbc_pkg::OFF_W;
    localparam int CYL_W        = dtbc_pkg::CYL_W;
    localparam int SPC_W        = dtbc_pkg::SPC_W;
    localparam int SCL_W        = dtbc_pkg::SCL_W;
    localparam int CFG_W        = dtbc_pkg::CFG_W;
    localparam int CFG_IDX_W    = dtbc_pkg::CFG_IDX_W;
    localparam int LABEL_SECTOR = dtbc_pkg::LABEL_SECTOR;
    localparam int BSHIFT       = dtbc_pkg::BLOCK_SHIFT_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_WAIT   = 60;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 100;

    // Status codes
    localparam dtbc_pkg::t_status ST_OK      = dtbc_pkg::ST_OK;
    localparam dtbc_pkg::t_status ST_EOF     = dtbc_pkg::ST_EOF;
    localparam dtbc_pkg::t_status ST_INVALID = dtbc_pkg::ST_INVALID;
    localparam dtbc_pkg::t_status ST_LABEL   = dtbc_pkg::ST_LABEL;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SPC   = dtbc_pkg::CFG_SPC;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = dtbc_pkg::CFG_SCALE;
    localparam logic [CFG_IDX_W-1:0] REG_RAW   = dtbc_pkg::CFG_RAW_OFF;

    typedef struct {
        logic [BLK_W-1:0] block;
        logic [CNT_W-1:0] count;
        logic             rd;
        logic             wlab;
        logic [BLK_W-1:0] psize;
        logic [OFF_W-1:0] poff;
    } t_xfer_req;

    typedef struct {
        dtbc_pkg::t_status status;
        logic [CNT_W-1:0]  cnt_out;
        logic [CNT_W-1:0]  resid;
        logic [CYL_W-1:0]  cyl;
    } t_xfer_res;

    typedef struct {
        int        phase;
        t_xfer_req req;
        bit        typed;
        t_xfer_res res;
    } t_dir_row;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [BLK_W-1:0]     i_block_number = '0;
    logic [CNT_W-1:0]     i_byte_count = '0;
    logic                 i_is_read = 1'b0;
    logic                 i_label_writable = 1'b0;
    logic [BLK_W-1:0]     i_partition_size = '0;
    logic [OFF_W-1:0]     i_partition_offset = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_strobe;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_byte_count_out;
    logic [CNT_W-1:0]     o_residual_count;
    logic [CYL_W-1:0]     o_cylinder;

    // Shadow copy of the configuration registers
    logic [SPC_W-1:0] spc_q = '0;
    logic [SCL_W-1:0] scale_q = 7'd1;
    logic [OFF_W-1:0] raw_q = '0;

    t_xfer_res pending_results[$];
    t_dir_row  dir_tab[$];
    int        mismatches = 0;
    int        cycle_cnt = 0;

    disk_transfer_bounds_check #(.BLOCK_SHIFT(BSHIFT)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_block_number     (i_block_number),
        .i_byte_count       (i_byte_count),
        .i_is_read          (i_is_read),
        .i_label_writable   (i_label_writable),
        .i_partition_size   (i_partition_size),
        .i_partition_offset (i_partition_offset),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_byte_count_out   (o_byte_count_out),
        .o_residual_count   (o_residual_count),
        .o_cylinder         (o_cylinder)
    );

    always #2 i_clk = ~i_clk;

    // Run-time limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Bounds check of one request against the current register settings
    function automatic t_xfer_res bounds_result(input t_xfer_req r);
        t_xfer_res   res;
        logic [63:0] blk, cnt, psz, poff, label, sz, cnt_out, abs_blk, cyl;
        blk     = 64'(r.block);
        cnt     = 64'(r.count);
        psz     = 64'(r.psize) * 64'(scale_q);
        poff    = 64'(r.poff) * 64'(scale_q);
        label   = 64'(raw_q) * 64'(scale_q) + 64'(LABEL_SECTOR);
        sz      = (cnt + (64'd1 << BSHIFT) - 64'd1) >> BSHIFT;
        cnt_out = cnt;
        cyl     = '0;
        res.status = ST_OK;
        if (spc_q == '0) begin
            res.status = ST_INVALID;
        end else if (blk + sz > psz) begin
            if (blk == psz) begin
                res.status = ST_EOF;
            end else if (blk > psz) begin
                res.status = ST_INVALID;
            end else begin
                // run over the end: keep only the blocks left
                sz      = psz - blk;
                cnt_out = sz << BSHIFT;
            end
        end
        if (res.status == ST_OK) begin
            abs_blk = blk + poff;
            if (abs_blk <= label && (LABEL_SECTOR == 0 || abs_blk + sz > label) &&
                !r.rd && !r.wlab) begin
                res.status = ST_LABEL;
            end else begin
                cyl = abs_blk / 64'(spc_q);
                if (cyl > 64'hFFFF_FFFF)
                    cyl = 64'hFFFF_FFFF;
            end
        end
        res.cnt_out = cnt_out[CNT_W-1:0];
        res.resid   = (res.status != ST_OK) ? r.count : '0;
        res.cyl     = cyl[CYL_W-1:0];
        return res;
    endfunction

    // Random request, mostly aimed at the partition end and the label block
    function automatic t_xfer_req random_request();
        t_xfer_req   r;
        logic [63:0] scaled, lim, nblk, back, blk;
        int          sel;
        r.rd   = 1'($urandom_range(1));
        r.wlab = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 35)      r.count = CNT_W'($urandom_range(4096));
        else if (sel < 55) r.count = CNT_W'(512 * $urandom_range(64));
        else if (sel < 65) r.count = ($urandom_range(1) != 0) ? '1 : CNT_W'($urandom_range(1));
        else               r.count = CNT_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 5)       r.psize = '0;
        else if (sel < 10) r.psize = '1;
        else               r.psize = $urandom >> (32 - $urandom_range(1, 32));
        r.poff = ($urandom_range(1) != 0) ? $urandom : ($urandom >> $urandom_range(31));
        scaled = 64'(r.psize) * 64'(scale_q);
        lim    = (scaled > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : scaled;
        nblk   = (64'(r.count) + (64'd1 << BSHIFT) - 64'd1) >> BSHIFT;
        sel = $urandom_range(99);
        if (sel < 20) begin
            // inside the whole-disk partition, around the label block
            r.poff = raw_q;
            blk    = 64'($urandom_range(3));
            r.rd   = ($urandom_range(3) == 0);
            if (r.psize == '0)
                r.psize = $urandom_range(1, 1000);
        end else if (sel < 45) begin
            blk = {$urandom, $urandom} % (lim + 64'd1);
        end else if (sel < 62) begin
            back = 64'($urandom_range(0, 32'(nblk) + 2));
            blk  = (scaled >= back) ? scaled - back : '0;
            if (blk > lim)
                blk = lim;
        end else if (sel < 72) begin
            blk = lim;
        end else if (sel < 80) begin
            blk = (lim < 64'hFFFF_FFF0) ? lim + 64'($urandom_range(1, 3)) : 64'($urandom);
        end else begin
            blk = 64'($urandom);
        end
        r.block = blk[BLK_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input int phase, input logic [BLK_W-1:0] blk,
                                    input logic [CNT_W-1:0] cnt, input logic rd,
                                    input logic wlab, input logic [BLK_W-1:0] psz,
                                    input logic [OFF_W-1:0] poff, input bit typed,
                                    input dtbc_pkg::t_status st,
                                    input logic [CNT_W-1:0] cnt_out,
                                    input logic [CNT_W-1:0] resid,
                                    input logic [CYL_W-1:0] cyl);
        t_dir_row row;
        row.phase       = phase;
        row.req.block   = blk;
        row.req.count   = cnt;
        row.req.rd      = rd;
        row.req.wlab    = wlab;
        row.req.psize   = psz;
        row.req.poff    = poff;
        row.typed       = typed;
        row.res.status  = st;
        row.res.cnt_out = cnt_out;
        row.res.resid   = resid;
        row.res.cyl     = cyl;
        dir_tab.push_back(row);
    endfunction

    // Drive one request beat after a random idle gap, record its expected result
    task automatic issue_request(input t_xfer_req r, input bit typed, input t_xfer_res known,
                                 input int idle_pct);
        int gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 200)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_block_number     <= r.block;
        i_byte_count       <= r.count;
        i_is_read          <= r.rd;
        i_label_writable   <= r.wlab;
        i_partition_size   <= r.psize;
        i_partition_offset <= r.poff;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (typed)
            pending_results.push_back(known);
        else
            pending_results.push_back(bounds_result(r));
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_config(input logic [SPC_W-1:0] spc, input logic [SCL_W-1:0] scale,
                                input logic [OFF_W-1:0] raw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SPC;
        i_cfg_wdata <= CFG_W'(spc);
        @(posedge i_clk);
        spc_q = spc;
        i_cfg_index <= REG_SCALE;
        i_cfg_wdata <= CFG_W'(scale);
        @(posedge i_clk);
        scale_q = scale;
        i_cfg_index <= REG_RAW;
        i_cfg_wdata <= CFG_W'(raw);
        @(posedge i_clk);
        raw_q = raw;
        i_cfg_we <= 1'b0;
    endtask

    // Result checker: every strobe beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_xfer_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected: status %0d count %0h", $time,
                         o_status, o_byte_count_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_status);
                    mismatches++;
                end
                if (o_byte_count_out !== want.cnt_out) begin
                    $display("%0t: byte_count_out expected %0h actual %0h", $time,
                             want.cnt_out, o_byte_count_out);
                    mismatches++;
                end
                if (o_residual_count !== want.resid) begin
                    $display("%0t: residual_count expected %0h actual %0h", $time,
                             want.resid, o_residual_count);
                    mismatches++;
                end
                if (o_cylinder !== want.cyl) begin
                    $display("%0t: cylinder expected %0h actual %0h", $time, want.cyl,
                             o_cylinder);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [SPC_W-1:0] dir_spc[4];
        logic [SCL_W-1:0] dir_scale[4];
        logic [OFF_W-1:0] dir_raw[4];
        logic [SPC_W-1:0] spc;
        logic [SCL_W-1:0] scale;
        logic [OFF_W-1:0] raw;
        t_xfer_res        no_res;
        int               cur_phase;
        int               idle_pct;

        no_res = '{ST_OK, '0, '0, '0};
        // directed settings; the first one is the reset state and is not written
        dir_spc   = '{24'd0, 24'd63, 24'd1, 24'hFF_FFFF};
        dir_scale = '{7'd1, 7'd1, 7'd64, 7'd7};
        dir_raw   = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd12345};

        // zero geometry after reset: all invalid
        add_row(0, 32'd0, 24'h123, 1, 0, 32'd100, 32'd0, 1, ST_INVALID, 24'h123, 24'h123, 0);
        add_row(0, '1, '1, 0, 1, '1, '1, 1, ST_INVALID, '1, '1, 0);
        // partition end, truncation and label block, label at block 1
        add_row(1, 32'd100, 24'd512, 1, 0, 32'd100, 32'd0, 1, ST_EOF, 24'd512, 24'd512, 0);
        add_row(1, 32'd101, 24'd512, 1, 0, 32'd100, 32'd0, 1, ST_INVALID, 24'd512, 24'd512,
                0);
        add_row(1, 32'd100, 24'd0, 1, 0, 32'd100, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd98, 24'd4096, 0, 0, 32'd100, 32'd700, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd1024, 0, 0, 32'd1000, 32'd0, 1, ST_LABEL, 24'd1024, 24'd1024,
                0);
        add_row(1, 32'd0, 24'd1024, 0, 1, 32'd1000, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd1024, 1, 0, 32'd1000, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd1, 24'd1, 0, 0, 32'd1000, 32'd0, 1, ST_LABEL, 24'd1, 24'd1, 0);
        add_row(1, 32'd2, 24'd512, 0, 0, 32'd1000, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd512, 0, 0, 32'd1000, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd0, 0, 0, 32'd1000, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd4096, 0, 0, 32'd1, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd0, 24'd4096, 0, 0, 32'd2, 32'd0, 1, ST_LABEL, 24'd1024, 24'd4096, 0);
        add_row(1, 32'd0, '1, 1, 0, '1, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(1, 32'd10, 24'd1, 1, 0, 32'd11, 32'd0, 0, ST_OK, 0, 0, 0);
        // scale 64 and largest offsets: saturated cylinder, label at the top
        add_row(2, '1, '1, 1, 0, '1, '1, 1, ST_OK, '1, 24'd0, '1);
        add_row(2, 32'd1, 24'd512, 0, 0, 32'd10, '1, 1, ST_LABEL, 24'd512, 24'd512, 0);
        add_row(2, 32'd0, 24'd0, 0, 0, 32'd10, '1, 0, ST_OK, 0, 0, 0);
        add_row(2, 32'd1, 24'd512, 0, 1, 32'd10, '1, 0, ST_OK, 0, 0, 0);
        // widest cylinder size, odd scale
        add_row(3, 32'd5, 24'd100, 1, 0, 32'd1, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(3, 32'd0, 24'd0, 1, 0, 32'd0, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(3, 32'd0, 24'd1, 1, 0, 32'd0, 32'd0, 1, ST_EOF, 24'd1, 24'd1, 0);
        add_row(3, 32'd0, 24'd1024, 0, 0, 32'd100, 32'd12345, 1, ST_LABEL, 24'd1024,
                24'd1024, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cur_phase = 0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].phase != cur_phase) begin
                wait_results_done();
                cur_phase = dir_tab[k].phase;
                write_config(dir_spc[cur_phase], dir_scale[cur_phase], dir_raw[cur_phase]);
            end
            issue_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res, 0);
        end

        // random phases, each with its own settings and idle pattern
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 3)      spc = '0;
            else if (p == 1) spc = 24'd1;
            else if (p == 5) spc = '1;
            else if ($urandom_range(1) != 0) spc = SPC_W'($urandom_range(1, 255));
            else             spc = SPC_W'($urandom_range(1, 24'hFF_FFFF));
            if (p == 0)      scale = 7'd1;
            else if (p == 2) scale = 7'd64;
            else             scale = SCL_W'($urandom_range(1, 64));
            if (p == 4)      raw = '1;
            else if (p == 6) raw = '0;
            else if ($urandom_range(1) != 0) raw = $urandom_range(1, 5000);
            else             raw = $urandom;
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 80;
                default: idle_pct = 9;
            endcase
            wait_results_done();
            write_config(spc, scale, raw);
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue_request(random_request(), 0, no_res, idle_pct);
        end

        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dtbc_pkg.sv
hw/rtl/dtbc_front.sv
hw/rtl/dtbc_div_cell.sv
hw/rtl/disk_transfer_bounds_check.sv
verif/testbench.sv
